FILE: hw/rtl/mte_pkg.sv
`timescale 1ns / 1ps

package mte_pkg;

	// Table size and derived widths
	localparam int NUM_TIMERS = 64;
	localparam int TIMER_AW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int SCAN_W     = $clog2(NUM_TIMERS + 1);

	// Fixed field widths
	localparam int IDX_W  = 6;
	localparam int RUN_W  = 31;
	localparam int TICK_W = 32;

	// Command queue between front and back (depth is a power of two)
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// Report queue at the output (depth is a power of two)
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// Request type codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] timer_index;
		logic [RUN_W-1:0] run_length;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  expired_index;
		logic [TICK_W-1:0] expiry_tick;
		logic              final_report;
	} rpt_t;

	typedef enum logic [1:0] {
		CMD_TICK,
		CMD_START,
		CMD_STOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] index;
		logic [RUN_W-1:0] span;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} bk_state_t;

endpackage

FILE: hw/rtl/multi_timer_expiry_engine.sv
`timescale 1ns / 1ps
// Flow: an accepted request is written into the command queue, and the executor takes it from
// there once it is idle. A tick's reports are held one expiry behind the scan. The first is
// pushed when the scan finds a second expiry, or when the scan ends for a lone expiry.
// Execution: start and stop are carried out when taken. A tick holds the executor for a scan
// that reads one deadline per cycle while the report queue has room, and longer when it fills.
// Reset: arst_n clears the tick counter, stops every timer and empties both queues at once.

module multi_timer_expiry_engine import mte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  logic pop,
	output rpt_t report
);

	// Front to back: classified commands waiting in a short queue
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_take;

	// Back to report queue
	logic             out_push;
	rpt_t             out_data;
	logic [OQ_CW-1:0] out_count;

	// Accept each request while not full, drop the ones that do nothing, hold the rest in order
	mte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// Execute commands: arm and stop timers, advance the counter and scan the table on tick.
	// Hold the latest expiry back one step so the last one of a tick can be marked.
	mte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.out_count (out_count),
		.out_push  (out_push),
		.out_data  (out_data)
	);

	// Buffer reports so the scan only stalls when the consumer falls behind
	mte_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.out_push  (out_push),
		.out_data  (out_data),
		.out_count (out_count),
		.empty     (empty),
		.pop       (pop),
		.report    (report)
	);

endmodule

FILE: hw/rtl/mte_front.sv
`timescale 1ns / 1ps

module mte_front import mte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic cmd_valid,
	output cmd_t cmd,
	input  logic cmd_take
);

	cmd_t             cq_mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_CW-1:0] cnt_q;
	cmd_t             cls;
	logic             keep;
	logic             idx_ok;
	logic             wr;
	logic             rd;

	assign idx_ok = 32'(request.timer_index) < 32'(NUM_TIMERS);

	// Classify: drop unknown types and out-of-range indexes, fold a zero run length to one
	always_comb begin
		cls.index = request.timer_index;
		cls.span  = (request.run_length == '0) ? RUN_W'(1) : request.run_length;
		cls.kind  = CMD_TICK;
		keep      = 1'b0;
		case (request.req_type)
			REQ_TICK: begin
				cls.kind = CMD_TICK;
				keep     = 1'b1;
			end
			REQ_START: begin
				cls.kind = CMD_START;
				keep     = idx_ok;
			end
			REQ_STOP: begin
				cls.kind = CMD_STOP;
				keep     = idx_ok;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign full      = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign wr        = push && !full && keep;
	assign cmd_valid = (cnt_q != '0);
	assign rd        = cmd_take && cmd_valid;
	assign cmd       = cq_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + CQ_AW'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + CQ_AW'(1);
			cnt_q <= cnt_q + CQ_CW'(wr) - CQ_CW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) cq_mem_q[wr_ptr_q] <= cls;
	end

endmodule

FILE: hw/rtl/mte_outq.sv
`timescale 1ns / 1ps

module mte_outq import mte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             out_push,
	input  rpt_t             out_data,
	output logic [OQ_CW-1:0] out_count,
	output logic             empty,
	input  logic             pop,
	output rpt_t             report
);

	rpt_t             oq_mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             wr;
	logic             rd;

	assign wr        = out_push && (cnt_q != OQ_CW'(OQ_DEPTH));
	assign empty     = (cnt_q == '0);
	assign rd        = pop && !empty;
	assign report    = oq_mem_q[rd_ptr_q];
	assign out_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			cnt_q <= cnt_q + OQ_CW'(wr) - OQ_CW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) oq_mem_q[wr_ptr_q] <= out_data;
	end

endmodule

FILE: hw/rtl/mte_back.sv
`timescale 1ns / 1ps

module mte_back import mte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_take,
	input  logic [OQ_CW-1:0] out_count,
	output logic             out_push,
	output rpt_t             out_data
);

	bk_state_t             state_q, state_d;
	logic [TICK_W-1:0]     now_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [TICK_W-1:0]     deadline_mem [NUM_TIMERS];
	logic [TICK_W-1:0]     deadline_s1;
	logic [TIMER_AW-1:0]   addr_s1;
	logic                  v_s1;
	logic [SCAN_W-1:0]     issue_q;
	logic                  pend_v_q;
	logic [TIMER_AW-1:0]   pend_idx_q;
	logic [TIMER_AW-1:0]   cmd_addr;
	logic [OQ_CW:0]        oq_load;
	logic                  oq_room;
	logic                  issue_done;
	logic                  issue;
	logic                  hit;
	logic                  flush_push;

	assign cmd_addr   = TIMER_AW'(cmd.index);
	assign issue_done = (issue_q == SCAN_W'(NUM_TIMERS));
	// Room for the report the compare stage may push plus one more
	assign oq_load    = {1'b0, out_count} + (OQ_CW + 1)'(v_s1);
	assign oq_room    = oq_load < (OQ_CW + 1)'(OQ_DEPTH);
	assign hit        = v_s1 && running_q[addr_s1] && (deadline_s1 == now_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid && cmd.kind == CMD_TICK) state_d = BK_SCAN;
			end
			BK_SCAN: begin
				if (issue_done && !v_s1) state_d = BK_FLUSH;
			end
			BK_FLUSH: begin
				if (!pend_v_q || out_count != OQ_CW'(OQ_DEPTH)) state_d = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_take   = 1'b0;
		issue      = 1'b0;
		flush_push = 1'b0;
		out_push   = 1'b0;
		out_data   = '{expired_index: IDX_W'(pend_idx_q), expiry_tick: now_q,
			final_report: 1'b0};
		case (state_q)
			BK_IDLE: begin
				cmd_take = cmd_valid;
			end
			BK_SCAN: begin
				issue    = !issue_done && oq_room;
				// a new hit proves the held one was not the last
				out_push = hit && pend_v_q;
			end
			BK_FLUSH: begin
				flush_push            = pend_v_q && (out_count != OQ_CW'(OQ_DEPTH));
				out_push              = flush_push;
				out_data.final_report = 1'b1;
			end
			default: begin
				cmd_take = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			now_q      <= '0;
			running_q  <= '0;
			issue_q    <= '0;
			v_s1       <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			if (cmd_take) begin
				case (cmd.kind)
					CMD_TICK: begin
						now_q    <= now_q + TICK_W'(1);
						issue_q  <= '0;
						pend_v_q <= 1'b0;
					end
					CMD_START: running_q[cmd_addr] <= 1'b1;
					CMD_STOP:  running_q[cmd_addr] <= 1'b0;
					default:   running_q <= running_q;
				endcase
			end
			if (issue) issue_q <= issue_q + SCAN_W'(1);
			if (hit) begin
				running_q[addr_s1] <= 1'b0;
				pend_v_q           <= 1'b1;
				pend_idx_q         <= addr_s1;
			end
			if (flush_push) pend_v_q <= 1'b0;
		end
	end

	// Deadline store: one write port for start, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (cmd_take && cmd.kind == CMD_START)
			deadline_mem[cmd_addr] <= now_q + TICK_W'(cmd.span);
		if (issue) begin
			deadline_s1 <= deadline_mem[issue_q[TIMER_AW-1:0]];
			addr_s1     <= issue_q[TIMER_AW-1:0];
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_count != OQ_CW'(OQ_DEPTH))
		else $error("report pushed into a full queue");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BK_IDLE) |-> !cmd_take)
		else $error("command taken during a scan");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_data.final_report) |=> state_q == BK_IDLE)
		else $error("scan did not end after the last report");

	a_hit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		hit |=> !running_q[$past(addr_s1)])
		else $error("expired timer still running");

endmodule
